FILE: rtl/core/lzid_pkg.sv
package lzid_pkg;

    // fixed field widths
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 20;
    localparam int LEN_W      = 6;
    localparam int DIST_W     = 12;
    localparam int FLAG_CNT_W = 4;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LEN_W-1:0]      MIN_MATCH      = LEN_W'(3);
    localparam logic [FLAG_CNT_W-1:0] FLAGS_PER_CTRL = FLAG_CNT_W'(8);
    localparam logic [BYTE_W-1:0]     ALPHA_INDEX    = '0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_COLOR   = 2'd2;

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_ITEM    = 2'd1,
        PH_HIGH    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        B_IDLE  = 2'd0,
        B_READ  = 2'd1,
        B_WRITE = 2'd2
    } t_back_state;

    // one decoded operation for the copy engine
    typedef struct packed {
        logic              is_copy;
        logic [BYTE_W-1:0] lit;
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] distance;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_value;
        logic              last_of_run;
        logic              image_done;
    } t_pix;

endpackage

FILE: rtl/core/lzid_fifo.sv
module lzid_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CW-1:0]     r_cnt;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/lzid_front.sv
module lzid_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [lzid_pkg::BYTE_W-1:0]         i_byte,
    input  logic [lzid_pkg::CNT_W-1:0]          i_limit,
    input  logic                                i_narrow,
    input  logic [lzid_pkg::BYTE_W-1:0]         i_alpha,
    output logic                                o_cmd_push,
    output lzid_pkg::t_cmd                      o_cmd
);

    lzid_pkg::t_phase                      r_phase, n_phase;
    logic [lzid_pkg::BYTE_W-1:0]           r_flags, n_flags;
    logic [lzid_pkg::FLAG_CNT_W-1:0]       r_flags_left, n_flags_left;
    logic [lzid_pkg::BYTE_W-1:0]           r_low, n_low;
    logic [lzid_pkg::CNT_W-1:0]            r_count, n_count;

    logic                                  complete;
    logic                                  take_item;
    logic                                  high_byte;
    logic [2*lzid_pkg::BYTE_W-1:0]         word;
    logic [lzid_pkg::LEN_W-1:0]            len_raw;
    logic [lzid_pkg::LEN_W-1:0]            len_eff;
    logic [lzid_pkg::DIST_W-1:0]           distance;
    logic [lzid_pkg::CNT_W-1:0]            remaining;
    logic [lzid_pkg::FLAG_CNT_W-1:0]       left_dec;

    // front keeps its own pixel tally so it knows at once when the image is complete
    assign complete  = (r_count >= i_limit);
    assign take_item = (r_phase == lzid_pkg::PH_ITEM) && (r_flags_left != '0);
    assign high_byte = !take_item && (r_phase == lzid_pkg::PH_HIGH);
    assign word      = {i_byte, r_low};
    assign len_raw   = i_narrow
                     ? lzid_pkg::LEN_W'(word[3:0]) + lzid_pkg::MIN_MATCH
                     : lzid_pkg::LEN_W'(word[4:0]) + lzid_pkg::MIN_MATCH;
    assign distance  = i_narrow ? word[15:4] : {1'b0, word[15:5]};
    assign remaining = i_limit - r_count;
    // a copy that overruns the image is cut short
    assign len_eff   = (remaining < lzid_pkg::CNT_W'(len_raw))
                     ? remaining[lzid_pkg::LEN_W-1:0] : len_raw;
    assign left_dec  = (r_flags_left != '0) ? r_flags_left - 1'b1 : '0;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_flags      = r_flags;
        n_flags_left = r_flags_left;
        n_low        = r_low;
        n_count      = r_count;
        if (i_accept && !complete) begin
            if (take_item && !r_flags[0]) begin
                n_low   = i_byte;
                n_phase = lzid_pkg::PH_HIGH;
            end else if (take_item || high_byte) begin
                n_count      = take_item ? r_count + 1'b1
                                         : r_count + lzid_pkg::CNT_W'(len_eff);
                n_flags      = r_flags >> 1;
                n_flags_left = left_dec;
                n_phase      = (left_dec == '0) ? lzid_pkg::PH_CONTROL : lzid_pkg::PH_ITEM;
                if (n_count >= i_limit) begin
                    n_phase      = lzid_pkg::PH_CONTROL;
                    n_flags_left = '0;
                    n_flags      = '0;
                end
            end else begin
                n_flags      = i_byte;
                n_flags_left = lzid_pkg::FLAGS_PER_CTRL;
                n_phase      = lzid_pkg::PH_ITEM;
            end
        end
    end

    // outputs
    always_comb begin
        o_cmd_push     = i_accept && !complete && ((take_item && r_flags[0]) || high_byte);
        o_cmd.is_copy  = high_byte;
        o_cmd.lit      = (i_byte == i_alpha) ? lzid_pkg::ALPHA_INDEX : i_byte;
        o_cmd.len      = high_byte ? len_eff : lzid_pkg::LEN_W'(1);
        o_cmd.distance = distance;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lzid_pkg::PH_CONTROL;
            r_flags      <= '0;
            r_flags_left <= '0;
            r_low        <= '0;
            r_count      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_flags_left <= n_flags_left;
            r_low        <= n_low;
            r_count      <= n_count;
        end
    end

endmodule

FILE: rtl/core/lzid_back.sv
module lzid_back #(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  lzid_pkg::t_cmd              i_cmd,
    output logic                        o_cmd_pop,
    input  logic [lzid_pkg::CNT_W-1:0]  i_limit,
    input  logic                        i_out_full,
    output logic                        o_pix_push,
    output lzid_pkg::t_pix              o_pix
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int XW = ((AW > lzid_pkg::DIST_W) ? AW : lzid_pkg::DIST_W) + 1;

    lzid_pkg::t_back_state              r_state, n_state;
    logic [AW-1:0]                      r_ptr;
    logic                               r_wrapped;
    logic [lzid_pkg::CNT_W-1:0]         r_count;
    logic [lzid_pkg::LEN_W-1:0]         r_left;
    logic                               r_is_lit;
    logic [lzid_pkg::BYTE_W-1:0]        r_lit;
    logic [AW-1:0]                      r_dist;
    logic [lzid_pkg::BYTE_W-1:0]        r_window [WINDOW_DEPTH];
    logic [lzid_pkg::BYTE_W-1:0]        r_rd_data;
    logic                               r_rd_ok;

    logic [XW-1:0]                      dist_x;
    logic [XW-1:0]                      dist_m;
    logic [AW:0]                        src_x;
    logic [AW-1:0]                      src;
    logic                               mem_re;
    logic                               emit;
    logic [lzid_pkg::BYTE_W-1:0]        out_data;

    assign dist_x = XW'(i_cmd.distance);
    assign dist_m = (dist_x >= XW'(WINDOW_DEPTH)) ? dist_x - XW'(WINDOW_DEPTH) : dist_x;

    // source entry wraps around the window
    assign src_x = (r_ptr >= r_dist)
                 ? {1'b0, r_ptr} - {1'b0, r_dist}
                 : {1'b0, r_ptr} + (AW+1)'(WINDOW_DEPTH) - {1'b0, r_dist};
    assign src   = src_x[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lzid_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.is_copy ? lzid_pkg::B_READ : lzid_pkg::B_WRITE;
                end
            end
            lzid_pkg::B_READ: begin
                n_state = lzid_pkg::B_WRITE;
            end
            lzid_pkg::B_WRITE: begin
                if (!i_out_full) begin
                    n_state = (r_left == lzid_pkg::LEN_W'(1)) ? lzid_pkg::B_IDLE
                                                              : lzid_pkg::B_READ;
                end
            end
            default: begin
                n_state = lzid_pkg::B_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        mem_re    = 1'b0;
        emit      = 1'b0;
        case (r_state)
            lzid_pkg::B_IDLE:  o_cmd_pop = i_cmd_valid;
            lzid_pkg::B_READ:  mem_re    = 1'b1;
            lzid_pkg::B_WRITE: emit      = !i_out_full;
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
        // entries not yet written since reset read as zero
        out_data          = r_is_lit ? r_lit : (r_rd_ok ? r_rd_data : '0);
        o_pix_push        = emit;
        o_pix.pixel_value = out_data;
        o_pix.last_of_run = (r_left == lzid_pkg::LEN_W'(1));
        o_pix.image_done  = ((r_count + 1'b1) == i_limit);
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_window[r_ptr] <= out_data;
        end
        if (mem_re) begin
            r_rd_data <= r_window[src];
            r_rd_ok   <= r_wrapped || (src < r_ptr);
        end
        if (o_cmd_pop) begin
            r_is_lit <= !i_cmd.is_copy;
            r_lit    <= i_cmd.lit;
            r_dist   <= dist_m[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lzid_pkg::B_IDLE;
            r_ptr     <= '0;
            r_wrapped <= 1'b0;
            r_count   <= '0;
            r_left    <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd_pop) begin
                r_left <= i_cmd.len;
            end else if (emit) begin
                r_left <= r_left - 1'b1;
            end
            if (emit) begin
                r_count <= r_count + 1'b1;
                if (r_ptr == AW'(WINDOW_DEPTH - 1)) begin
                    r_ptr     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/lzss_image_decompressor_top.sv
// lzss image decompressor
// input channel: one compressed byte per transaction on i_stream_byte, taken while
// o_full is low and i_push is high. control bytes and command low bytes give no pixel.
// result channel: one decoded pixel per transaction; o_pixel_value, o_last_of_run and
// o_image_done are valid while o_empty is low and leave on i_pop.
// configuration: write i_cfg_data to register i_cfg_index with i_cfg_we, only while
// the block is idle (0 pixel count, 1 narrow length, 2 alpha color).
// the copy engine loads each operation from the command queue; for each pixel of a
// back-reference it then reads the history window and, in a separate state, writes
// and emits the pixel. a literal skips the window read. the engine waits in the
// write state while the output queue is full.
// a small command queue lets the parser keep taking bytes while a copy runs.
// reset: synchronous, active low; the window reads as zeros until written, tracked
// by a fill pointer, so the block takes bytes right after reset.
// when the pixel receiver stalls the output queue fills, the copy engine waits,
// the command queue fills and o_full rises.
module lzss_image_decompressor_top #(
    parameter int WINDOW_DEPTH  = 4096,
    parameter int MAX_DIMENSION = 1023
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [lzid_pkg::BYTE_W-1:0]        i_stream_byte,
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic [lzid_pkg::BYTE_W-1:0]        o_pixel_value,
    output logic                               o_last_of_run,
    output logic                               o_image_done,
    input  logic                               i_cfg_we,
    input  logic [lzid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lzid_pkg::CNT_W-1:0]         i_cfg_data
);

    localparam logic [lzid_pkg::CNT_W-1:0] MAX_PIXELS =
        lzid_pkg::CNT_W'(MAX_DIMENSION * MAX_DIMENSION);
    localparam int CMD_DEPTH = 2;
    localparam int PIX_DEPTH = 4;

    logic [lzid_pkg::CNT_W-1:0]   r_pixel_count;
    logic                         r_narrow;
    logic [lzid_pkg::BYTE_W-1:0]  r_alpha;
    logic [lzid_pkg::CNT_W-1:0]   limit;

    logic                         accept;
    logic                         cmd_push;
    lzid_pkg::t_cmd               cmd_in;
    logic                         cmd_full;
    logic                         cmd_empty;
    logic                         cmd_pop;
    lzid_pkg::t_cmd               cmd_out;
    logic                         pix_push;
    logic                         pix_full;
    lzid_pkg::t_pix               pix_in;
    lzid_pkg::t_pix               pix_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= '0;
            r_narrow      <= 1'b0;
            r_alpha       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lzid_pkg::REG_PIXEL_COUNT:   r_pixel_count <= i_cfg_data;
                lzid_pkg::REG_NARROW_LENGTH: r_narrow      <= i_cfg_data[0];
                lzid_pkg::REG_ALPHA_COLOR:   r_alpha       <= i_cfg_data[lzid_pkg::BYTE_W-1:0];
                default: begin
                    r_narrow <= r_narrow;
                end
            endcase
        end
    end

    assign limit  = (r_pixel_count > MAX_PIXELS) ? MAX_PIXELS : r_pixel_count;
    assign accept = i_push && !o_full;
    assign o_full = cmd_full;

    lzid_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_stream_byte),
        .i_limit    (limit),
        .i_narrow   (r_narrow),
        .i_alpha    (r_alpha),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    lzid_fifo #(
        .DATA_W ($bits(lzid_pkg::t_cmd)),
        .DEPTH  (CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    lzid_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_limit     (limit),
        .i_out_full  (pix_full),
        .o_pix_push  (pix_push),
        .o_pix       (pix_in)
    );

    lzid_fifo #(
        .DATA_W ($bits(lzid_pkg::t_pix)),
        .DEPTH  (PIX_DEPTH)
    ) u_pix_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pix_push),
        .i_data  (pix_in),
        .o_full  (pix_full),
        .i_pop   (i_pop),
        .o_data  (pix_out),
        .o_empty (o_empty)
    );

    assign o_pixel_value = pix_out.pixel_value;
    assign o_last_of_run = pix_out.last_of_run;
    assign o_image_done  = pix_out.image_done;

    // copy engine must never emit into a full output queue
    a_no_pix_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pix_push && pix_full))
        else $error("pixel pushed into full output queue");

    // parser only issues commands when the queue has room
    a_no_cmd_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd_push && cmd_full))
        else $error("command pushed into full queue");

    // commands are issued only for accepted bytes
    a_cmd_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> accept)
        else $error("command without accepted byte");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

endmodule
